### src/pspr_pkg.sv
// pspr_pkg: shared types and constants of the priority slot pool
// holds default sizes, status codes and the control group sent down the cell row
// no dependencies

package pspr_pkg;

	// default pool geometry
	localparam int SLOTS_PER_KIND_DEF = 64;
	localparam int KINDS_DEF          = 4;

	// fixed field widths
	localparam int PRIO_W    = 4;
	localparam int LIFE_W    = 16;
	localparam int ELAPSED_W = 8;
	localparam int KIND_IN_W = 2;
	localparam int LIMIT_W   = 7;
	localparam int STATUS_W  = 3;
	localparam int SLOT_OUT_W = 6;

	localparam logic [LIMIT_W-1:0] CHILD_LIMIT_RST = 7'd48;

	// command codes
	localparam logic CMD_SPAWN = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_PLACED_FREE  = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_PLACED_EVICT = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_NO_SLOT      = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_NO_GROUND    = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_TICK_DONE    = 3'd4;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		logic                  tick;
		logic                  wr;
		logic [KIND_IN_W-1:0]  kind;
		logic [PRIO_W-1:0]     prio;
		logic [LIFE_W-1:0]     life;
		logic [ELAPSED_W-1:0]  elapsed;
	} cell_ctrl_t;

endpackage

### src/priority_slot_pool_replacement.sv
// priority_slot_pool_replacement: top level of the priority-aware slot pool
// a sequencer and a row of SLOTS_PER_KIND cells through which a scan token travels
// depends on pspr_pkg, pspr_cell, pspr_seq
//
//  channel   handshake                  payload
//  command   start / busy               command ground_found kind priority_req
//                                        life_ticks elapsed_ticks
//  config    child_limit_wr             child_limit
//  result    done (one-cycle strobe)    status slot_index
//
// a spawn goes from acceptance through the launch register, then the token steps a cell a cycle
// along the row, and the result beat is registered when the token leaves the last cell
// a tick has all cells age their slots at once; a refused spawn gives its result straight from idle
// for a tick or a scan, busy is high from the cycle after acceptance and drops in the cycle of the result beat
// the receiver cannot stall; the result beat is on the ports for exactly one cycle
// reset clears all active flags and loads child_limit with 48; no clearing pass

module priority_slot_pool_replacement #(
	parameter int SLOTS_PER_KIND = pspr_pkg::SLOTS_PER_KIND_DEF,
	parameter int KINDS          = pspr_pkg::KINDS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               command,
	input  logic                               ground_found,
	input  logic [pspr_pkg::KIND_IN_W-1:0]     kind,
	input  logic [pspr_pkg::PRIO_W-1:0]        priority_req,
	input  logic [pspr_pkg::LIFE_W-1:0]        life_ticks,
	input  logic [pspr_pkg::ELAPSED_W-1:0]     elapsed_ticks,
	input  logic                               child_limit_wr,
	input  logic [pspr_pkg::LIMIT_W-1:0]       child_limit,
	output logic                               done,
	output logic [pspr_pkg::STATUS_W-1:0]      status,
	output logic [pspr_pkg::SLOT_OUT_W-1:0]    slot_index
);

	localparam int IDX_W = $clog2(SLOTS_PER_KIND);
	localparam int CNT_W = $clog2(SLOTS_PER_KIND + 1);

	pspr_pkg::cell_ctrl_t         ctrl;
	logic [IDX_W-1:0]             wr_idx;
	logic                         launch;

	// token links, link i feeds cell i
	logic                         t_valid   [SLOTS_PER_KIND+1];
	logic [CNT_W-1:0]             t_count   [SLOTS_PER_KIND+1];
	logic                         t_c_found [SLOTS_PER_KIND+1];
	logic [IDX_W-1:0]             t_c_idx   [SLOTS_PER_KIND+1];
	logic [pspr_pkg::LIFE_W-1:0]  t_c_life  [SLOTS_PER_KIND+1];
	logic                         t_n_free  [SLOTS_PER_KIND+1];
	logic                         t_n_found [SLOTS_PER_KIND+1];
	logic [IDX_W-1:0]             t_n_idx   [SLOTS_PER_KIND+1];
	logic [pspr_pkg::LIFE_W-1:0]  t_n_life  [SLOTS_PER_KIND+1];

	// fresh token at the head of the row
	assign t_valid[0]   = launch;
	assign t_count[0]   = '0;
	assign t_c_found[0] = 1'b0;
	assign t_c_idx[0]   = '0;
	assign t_c_life[0]  = '0;
	assign t_n_free[0]  = 1'b0;
	assign t_n_found[0] = 1'b0;
	assign t_n_idx[0]   = '0;
	assign t_n_life[0]  = '0;

	// row of slot cells
	for (genvar i = 0; i < SLOTS_PER_KIND; i++) begin : g_cell
		pspr_cell #(
			.KINDS    (KINDS),
			.IDX_W    (IDX_W),
			.CNT_W    (CNT_W),
			.CELL_IDX (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.wr_idx      (wr_idx),
			.in_valid    (t_valid[i]),
			.in_count    (t_count[i]),
			.in_c_found  (t_c_found[i]),
			.in_c_idx    (t_c_idx[i]),
			.in_c_life   (t_c_life[i]),
			.in_n_free   (t_n_free[i]),
			.in_n_found  (t_n_found[i]),
			.in_n_idx    (t_n_idx[i]),
			.in_n_life   (t_n_life[i]),
			.out_valid   (t_valid[i+1]),
			.out_count   (t_count[i+1]),
			.out_c_found (t_c_found[i+1]),
			.out_c_idx   (t_c_idx[i+1]),
			.out_c_life  (t_c_life[i+1]),
			.out_n_free  (t_n_free[i+1]),
			.out_n_found (t_n_found[i+1]),
			.out_n_idx   (t_n_idx[i+1]),
			.out_n_life  (t_n_life[i+1])
		);
	end

	// sequencer
	pspr_seq #(
		.KINDS (KINDS),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.ground_found   (ground_found),
		.kind           (kind),
		.priority_req   (priority_req),
		.life_ticks     (life_ticks),
		.elapsed_ticks  (elapsed_ticks),
		.child_limit_wr (child_limit_wr),
		.child_limit    (child_limit),
		.done           (done),
		.status         (status),
		.slot_index     (slot_index),
		.ctrl           (ctrl),
		.wr_idx         (wr_idx),
		.launch         (launch),
		.last_valid     (t_valid[SLOTS_PER_KIND]),
		.last_count     (t_count[SLOTS_PER_KIND]),
		.last_c_found   (t_c_found[SLOTS_PER_KIND]),
		.last_c_idx     (t_c_idx[SLOTS_PER_KIND]),
		.last_n_free    (t_n_free[SLOTS_PER_KIND]),
		.last_n_found   (t_n_found[SLOTS_PER_KIND]),
		.last_n_idx     (t_n_idx[SLOTS_PER_KIND])
	);

endmodule

### src/pspr_cell.sv
// pspr_cell: one column of the slot pools (the same slot index in every kind)
// updates the passing scan token with its own slot and applies ticks and writes
// depends on pspr_pkg

module pspr_cell #(
	parameter int KINDS    = pspr_pkg::KINDS_DEF,
	parameter int IDX_W    = 6,
	parameter int CNT_W    = 7,
	parameter int CELL_IDX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pspr_pkg::cell_ctrl_t          ctrl,
	input  logic [IDX_W-1:0]              wr_idx,
	// scan token from the left neighbour
	input  logic                          in_valid,
	input  logic [CNT_W-1:0]              in_count,
	input  logic                          in_c_found,
	input  logic [IDX_W-1:0]              in_c_idx,
	input  logic [pspr_pkg::LIFE_W-1:0]   in_c_life,
	input  logic                          in_n_free,
	input  logic                          in_n_found,
	input  logic [IDX_W-1:0]              in_n_idx,
	input  logic [pspr_pkg::LIFE_W-1:0]   in_n_life,
	// scan token to the right neighbour
	output logic                          out_valid,
	output logic [CNT_W-1:0]              out_count,
	output logic                          out_c_found,
	output logic [IDX_W-1:0]              out_c_idx,
	output logic [pspr_pkg::LIFE_W-1:0]   out_c_life,
	output logic                          out_n_free,
	output logic                          out_n_found,
	output logic [IDX_W-1:0]              out_n_idx,
	output logic [pspr_pkg::LIFE_W-1:0]   out_n_life
);

	localparam int KIND_W = (KINDS > 1) ? $clog2(KINDS) : 1;
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic                         act_q  [KINDS];
	logic [pspr_pkg::PRIO_W-1:0]  prio_q [KINDS];
	logic [pspr_pkg::LIFE_W-1:0]  life_q [KINDS];

	logic [KIND_W-1:0]            ksel;
	logic                         cur_act;
	logic [pspr_pkg::PRIO_W-1:0]  cur_prio;
	logic [pspr_pkg::LIFE_W-1:0]  cur_life;
	logic                         is_child;
	logic                         my_wr;

	logic [CNT_W-1:0]             nx_count;
	logic                         nx_c_found;
	logic [IDX_W-1:0]             nx_c_idx;
	logic [pspr_pkg::LIFE_W-1:0]  nx_c_life;
	logic                         nx_n_free;
	logic                         nx_n_found;
	logic [IDX_W-1:0]             nx_n_idx;
	logic [pspr_pkg::LIFE_W-1:0]  nx_n_life;

	// own slot of the requested kind
	assign ksel     = KIND_W'(ctrl.kind);
	assign cur_act  = act_q[ksel];
	assign cur_prio = prio_q[ksel];
	assign cur_life = life_q[ksel];
	assign is_child = cur_act && (cur_prio == '0);
	assign my_wr    = ctrl.wr && (wr_idx == MY_IDX);

	// fold this slot into the token
	always_comb begin
		nx_count   = in_count + CNT_W'(is_child);
		nx_c_found = in_c_found;
		nx_c_idx   = in_c_idx;
		nx_c_life  = in_c_life;
		nx_n_free  = in_n_free;
		nx_n_found = in_n_found;
		nx_n_idx   = in_n_idx;
		nx_n_life  = in_n_life;
		// least-life priority-zero candidate, first wins ties
		if (is_child && (!in_c_found || cur_life < in_c_life)) begin
			nx_c_found = 1'b1;
			nx_c_idx   = MY_IDX;
			nx_c_life  = cur_life;
		end
		// normal scan freezes at the first free slot
		if (!in_n_free) begin
			if (!cur_act) begin
				nx_n_free  = 1'b1;
				nx_n_found = 1'b1;
				nx_n_idx   = MY_IDX;
			end else if (cur_prio <= ctrl.prio && (!in_n_found || cur_life < in_n_life)) begin
				nx_n_found = 1'b1;
				nx_n_idx   = MY_IDX;
				nx_n_life  = cur_life;
			end
		end
	end

	// token valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	// token payload
	always_ff @(posedge clk) begin
		out_count   <= nx_count;
		out_c_found <= nx_c_found;
		out_c_idx   <= nx_c_idx;
		out_c_life  <= nx_c_life;
		out_n_free  <= nx_n_free;
		out_n_found <= nx_n_found;
		out_n_idx   <= nx_n_idx;
		out_n_life  <= nx_n_life;
	end

	// active flags: tick ageing and placement
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KINDS; k++) begin
				act_q[k] <= 1'b0;
			end
		end else begin
			for (int k = 0; k < KINDS; k++) begin
				if (ctrl.tick) begin
					if (act_q[k] && life_q[k] <= pspr_pkg::LIFE_W'(ctrl.elapsed)) begin
						act_q[k] <= 1'b0;
					end
				end else if (my_wr && ksel == KIND_W'(k)) begin
					act_q[k] <= 1'b1;
				end
			end
		end
	end

	// priority and life
	always_ff @(posedge clk) begin
		for (int k = 0; k < KINDS; k++) begin
			if (ctrl.tick) begin
				if (act_q[k]) begin
					life_q[k] <= (life_q[k] > pspr_pkg::LIFE_W'(ctrl.elapsed))
						? (life_q[k] - pspr_pkg::LIFE_W'(ctrl.elapsed)) : '0;
				end
			end else if (my_wr && ksel == KIND_W'(k)) begin
				prio_q[k] <= ctrl.prio;
				life_q[k] <= ctrl.life;
			end
		end
	end

endmodule

### src/pspr_seq.sv
// pspr_seq: command sequencer of the slot pool
// takes commands, launches the scan token, decides placement and drives results
// depends on pspr_pkg

module pspr_seq #(
	parameter int KINDS = pspr_pkg::KINDS_DEF,
	parameter int IDX_W = 6,
	parameter int CNT_W = 7
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// command side
	input  logic                               start,
	output logic                               busy,
	input  logic                               command,
	input  logic                               ground_found,
	input  logic [pspr_pkg::KIND_IN_W-1:0]     kind,
	input  logic [pspr_pkg::PRIO_W-1:0]        priority_req,
	input  logic [pspr_pkg::LIFE_W-1:0]        life_ticks,
	input  logic [pspr_pkg::ELAPSED_W-1:0]     elapsed_ticks,
	// configuration
	input  logic                               child_limit_wr,
	input  logic [pspr_pkg::LIMIT_W-1:0]       child_limit,
	// result side
	output logic                               done,
	output logic [pspr_pkg::STATUS_W-1:0]      status,
	output logic [pspr_pkg::SLOT_OUT_W-1:0]    slot_index,
	// cell row
	output pspr_pkg::cell_ctrl_t               ctrl,
	output logic [IDX_W-1:0]                   wr_idx,
	output logic                               launch,
	input  logic                               last_valid,
	input  logic [CNT_W-1:0]                   last_count,
	input  logic                               last_c_found,
	input  logic [IDX_W-1:0]                   last_c_idx,
	input  logic                               last_n_free,
	input  logic                               last_n_found,
	input  logic [IDX_W-1:0]                   last_n_idx
);

	localparam int CMP_W = (CNT_W > pspr_pkg::LIMIT_W) ? CNT_W : pspr_pkg::LIMIT_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_TICK = 3'b010,
		S_SCAN = 3'b100
	} state_t;

	state_t                             state_q;
	logic                               launch_q;
	logic [pspr_pkg::LIMIT_W-1:0]       limit_q;
	logic [pspr_pkg::KIND_IN_W-1:0]     kind_q;
	logic [pspr_pkg::PRIO_W-1:0]        prio_q;
	logic [pspr_pkg::LIFE_W-1:0]        life_q;
	logic [pspr_pkg::ELAPSED_W-1:0]     elapsed_q;
	logic                               done_q;
	logic [pspr_pkg::STATUS_W-1:0]      status_q;
	logic [pspr_pkg::SLOT_OUT_W-1:0]    slot_q;

	logic                               accept;
	logic                               kind_ok;
	logic                               use_child;
	logic                               pick_found;
	logic                               pick_evict;
	logic [IDX_W-1:0]                   pick_idx;

	assign accept  = start && (state_q == S_IDLE);
	assign kind_ok = (32'(kind) < KINDS);
	assign busy    = (state_q != S_IDLE);

	// placement decision at the end of the row
	assign use_child  = (prio_q == '0) && last_c_found
		&& (CMP_W'(last_count) >= CMP_W'(limit_q));
	assign pick_found = use_child || last_n_found;
	assign pick_evict = use_child || !last_n_free;
	assign pick_idx   = use_child ? last_c_idx : last_n_idx;

	// broadcast to the cells
	always_comb begin
		ctrl.tick    = (state_q == S_TICK);
		ctrl.wr      = (state_q == S_SCAN) && last_valid && pick_found;
		ctrl.kind    = kind_q;
		ctrl.prio    = prio_q;
		ctrl.life    = life_q;
		ctrl.elapsed = elapsed_q;
	end
	assign wr_idx       = pick_idx;
	assign launch       = launch_q;

	assign done       = done_q;
	assign status     = status_q;
	assign slot_index = slot_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= pspr_pkg::CHILD_LIMIT_RST;
		end else if (child_limit_wr) begin
			limit_q <= child_limit;
		end
	end

	// request hold
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= kind;
			prio_q    <= priority_req;
			life_q    <= life_ticks;
			elapsed_q <= elapsed_ticks;
		end
	end

	// control flow and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			launch_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			launch_q <= 1'b0;
			done_q   <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (command == pspr_pkg::CMD_TICK) begin
							state_q <= S_TICK;
						end else if (!ground_found || !kind_ok) begin
							done_q <= 1'b1;
						end else begin
							state_q  <= S_SCAN;
							launch_q <= 1'b1;
						end
					end
				end
				S_TICK: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				S_SCAN: begin
					if (last_valid) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		priority if (state_q == S_IDLE && accept) begin
			status_q <= !ground_found ? pspr_pkg::STAT_NO_GROUND : pspr_pkg::STAT_NO_SLOT;
			slot_q   <= '0;
		end else if (state_q == S_TICK) begin
			status_q <= pspr_pkg::STAT_TICK_DONE;
			slot_q   <= '0;
		end else if (state_q == S_SCAN && last_valid) begin
			if (pick_found) begin
				status_q <= pick_evict ? pspr_pkg::STAT_PLACED_EVICT : pspr_pkg::STAT_PLACED_FREE;
				slot_q   <= pspr_pkg::SLOT_OUT_W'(pick_idx);
			end else begin
				status_q <= pspr_pkg::STAT_NO_SLOT;
				slot_q   <= '0;
			end
		end
	end

	// the token only ever leaves the row during a scan
	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		last_valid |-> state_q == S_SCAN)
		else $error("scan token left the row outside a scan");

	// a launch never coincides with a result beat
	a_launch_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		launch_q |-> !done_q)
		else $error("result beat during token launch");

	// tick results follow the tick cycle
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == S_TICK) |-> done_q && status_q == pspr_pkg::STAT_TICK_DONE)
		else $error("tick did not give its result");

	// only placements report a slot
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && slot_q != '0 |->
			status_q == pspr_pkg::STAT_PLACED_FREE || status_q == pspr_pkg::STAT_PLACED_EVICT)
		else $error("slot index given without a placement");

	// a scan is not dropped right after its launch
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		launch_q |=> state_q == S_SCAN)
		else $error("scan dropped right after launch");

endmodule

### tb/sv/tb_priority_slot_pool_replacement.sv
// tb_priority_slot_pool_replacement: self-checking bench for the priority slot pool
// predicts each result beat from its own model of the pools and compares it with the block
// depends on pspr_pkg and priority_slot_pool_replacement

module tb_priority_slot_pool_replacement;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = pspr_pkg::SLOTS_PER_KIND_DEF;
	localparam int POOLS = pspr_pkg::KINDS_DEF;
	localparam int QUIET_LIMIT = 1000;

	typedef struct {
		logic                           command;
		logic                           ground;
		logic [pspr_pkg::KIND_IN_W-1:0] kind;
		logic [pspr_pkg::PRIO_W-1:0]    prio;
		logic [pspr_pkg::LIFE_W-1:0]    life;
		logic [pspr_pkg::ELAPSED_W-1:0] elapsed;
		int                             gap;
		bit                             hold;
	} pool_cmd_t;

	typedef struct {
		logic [pspr_pkg::STATUS_W-1:0]   status;
		logic [pspr_pkg::SLOT_OUT_W-1:0] slot;
	} slot_outcome_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            start = 1'b0;
	logic                            busy;
	logic                            command = pspr_pkg::CMD_SPAWN;
	logic                            ground_found = 1'b0;
	logic [pspr_pkg::KIND_IN_W-1:0]  kind = '0;
	logic [pspr_pkg::PRIO_W-1:0]     priority_req = '0;
	logic [pspr_pkg::LIFE_W-1:0]     life_ticks = '0;
	logic [pspr_pkg::ELAPSED_W-1:0]  elapsed_ticks = '0;
	logic                            child_limit_wr = 1'b0;
	logic [pspr_pkg::LIMIT_W-1:0]    child_limit = pspr_pkg::CHILD_LIMIT_RST;
	logic                            done;
	logic [pspr_pkg::STATUS_W-1:0]   status;
	logic [pspr_pkg::SLOT_OUT_W-1:0] slot_index;

	// pool model
	bit                           pool_live [POOLS][SLOTS];
	logic [pspr_pkg::PRIO_W-1:0]  pool_prio [POOLS][SLOTS];
	logic [pspr_pkg::LIFE_W-1:0]  pool_life [POOLS][SLOTS];
	logic [pspr_pkg::LIMIT_W-1:0] limit_model;

	pool_cmd_t     cmd_backlog[$];
	slot_outcome_t expected_outcomes[$];
	pool_cmd_t     cur_cmd;
	bit            cmd_loaded = 1'b0;
	int            gap_left = 0;
	int            burst_left = 0;
	int            quiet_cycles = 0;
	int            mismatches = 0;
	int            cmds_sent = 0;
	int            beats_checked = 0;
	int            status_seen [5];

	priority_slot_pool_replacement dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.ground_found  (ground_found),
		.kind          (kind),
		.priority_req  (priority_req),
		.life_ticks    (life_ticks),
		.elapsed_ticks (elapsed_ticks),
		.child_limit_wr(child_limit_wr),
		.child_limit   (child_limit),
		.done          (done),
		.status        (status),
		.slot_index    (slot_index)
	);

	always #5 clk = ~clk;

	task report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// apply one accepted command to the pool model and queue its expected beat
	task predict_outcome(input pool_cmd_t c);
		slot_outcome_t res;
		int  k;
		int  zero_count;
		int  pick;
		bit  found;
		logic [pspr_pkg::LIFE_W-1:0] least;
		k = c.kind;
		found = 1'b0;
		pick = 0;
		least = '0;
		res.slot = '0;
		if (c.command == pspr_pkg::CMD_TICK) begin
			// age every live slot, saturating at zero
			for (int p = 0; p < POOLS; p++)
				for (int s = 0; s < SLOTS; s++)
					if (pool_live[p][s]) begin
						if (pool_life[p][s] > c.elapsed)
							pool_life[p][s] = pool_life[p][s] - c.elapsed;
						else
							pool_life[p][s] = '0;
						if (pool_life[p][s] == '0)
							pool_live[p][s] = 1'b0;
					end
			res.status = pspr_pkg::STAT_TICK_DONE;
		end else if (!c.ground) begin
			res.status = pspr_pkg::STAT_NO_GROUND;
		end else begin
			// forced eviction among priority-zero slots once the limit is reached
			if (c.prio == '0) begin
				zero_count = 0;
				for (int s = 0; s < SLOTS; s++)
					if (pool_live[k][s] && pool_prio[k][s] == '0)
						zero_count++;
				if (zero_count >= limit_model)
					for (int s = 0; s < SLOTS; s++)
						if (pool_live[k][s] && pool_prio[k][s] == '0 &&
								(!found || pool_life[k][s] < least)) begin
							found = 1'b1;
							pick = s;
							least = pool_life[k][s];
						end
			end
			// first free slot, else least-life slot of equal or lower priority
			if (!found)
				for (int s = 0; s < SLOTS; s++) begin
					if (!pool_live[k][s]) begin
						found = 1'b1;
						pick = s;
						break;
					end
					if (pool_prio[k][s] <= c.prio && (!found || pool_life[k][s] < least)) begin
						found = 1'b1;
						pick = s;
						least = pool_life[k][s];
					end
				end
			if (!found) begin
				res.status = pspr_pkg::STAT_NO_SLOT;
			end else begin
				res.status = pool_live[k][pick] ? pspr_pkg::STAT_PLACED_EVICT
					: pspr_pkg::STAT_PLACED_FREE;
				res.slot = pick[pspr_pkg::SLOT_OUT_W-1:0];
				pool_live[k][pick] = 1'b1;
				pool_prio[k][pick] = c.prio;
				pool_life[k][pick] = c.life;
			end
		end
		expected_outcomes.insert(expected_outcomes.size(), res);
	endtask

	// queue one command with its lead-in gap; bursts of back-to-back beats now and then
	task queue_cmd(input logic cmd, input logic gnd, input int kd, input int pr,
			input int lf, input int el);
		pool_cmd_t c;
		c.command = cmd;
		c.ground = gnd;
		c.kind = kd[pspr_pkg::KIND_IN_W-1:0];
		c.prio = pr[pspr_pkg::PRIO_W-1:0];
		c.life = lf[pspr_pkg::LIFE_W-1:0];
		c.elapsed = el[pspr_pkg::ELAPSED_W-1:0];
		c.hold = ($urandom_range(0, 39) == 0);
		if (burst_left > 0) begin
			burst_left--;
			c.gap = 0;
		end else if ($urandom_range(0, 12) == 0) begin
			burst_left = $urandom_range(5, 20);
			c.gap = 0;
		end else begin
			c.gap = $urandom_range(0, 8);
		end
		cmd_backlog.insert(cmd_backlog.size(), c);
	endtask

	// random commands aimed mostly at one pool
	task queue_random(input int n, input int focus, input int tick_pct, input int zero_pct);
		int kd;
		int pr;
		int lf;
		int el;
		int pick;
		for (int i = 0; i < n; i++) begin
			kd = ($urandom_range(0, 99) < 80) ? focus : $urandom_range(0, POOLS - 1);
			pr = ($urandom_range(0, 99) < zero_pct) ? 0 : $urandom_range(0, 15);
			pick = $urandom_range(0, 15);
			if (pick < 2)
				lf = $urandom_range(0, 3);
			else if (pick == 2)
				lf = 65535;
			else if (pick < 5)
				lf = $urandom_range(0, 65535);
			else
				lf = $urandom_range(20, 2000);
			pick = $urandom_range(0, 9);
			if (pick == 0)
				el = 255;
			else if (pick == 1)
				el = 0;
			else if (pick == 2)
				el = $urandom_range(0, 255);
			else
				el = $urandom_range(1, 40);
			queue_cmd(($urandom_range(0, 99) < tick_pct) ? pspr_pkg::CMD_TICK : pspr_pkg::CMD_SPAWN,
				($urandom_range(0, 19) != 0), kd, pr, lf, el);
		end
	endtask

	// wait until every queued command has gone and every beat has come back
	task wait_drained;
		while (cmd_backlog.size() != 0 || cmd_loaded || start || expected_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task write_limit(input int value);
		wait_drained();
		repeat (4) @(posedge clk);
		child_limit <= value[pspr_pkg::LIMIT_W-1:0];
		child_limit_wr <= 1'b1;
		limit_model = value[pspr_pkg::LIMIT_W-1:0];
		@(posedge clk);
		child_limit_wr <= 1'b0;
	endtask

	// driver: feeds the command port from the backlog
	always @(posedge clk) begin
		bit taken;
		taken = start && !busy;
		if (taken) begin
			predict_outcome(cur_cmd);
			cmds_sent++;
		end
		if (arst_n && (!start || taken)) begin
			if (!cmd_loaded && cmd_backlog.size() != 0 &&
					!(cmd_backlog[0].hold && expected_outcomes.size() != 0)) begin
				cur_cmd = cmd_backlog.pop_front();
				gap_left = cur_cmd.gap;
				cmd_loaded = 1'b1;
			end
			if (cmd_loaded && gap_left == 0) begin
				start <= 1'b1;
				command <= cur_cmd.command;
				ground_found <= cur_cmd.ground;
				kind <= cur_cmd.kind;
				priority_req <= cur_cmd.prio;
				life_ticks <= cur_cmd.life;
				elapsed_ticks <= cur_cmd.elapsed;
				cmd_loaded = 1'b0;
			end else begin
				start <= 1'b0;
				if (cmd_loaded)
					gap_left--;
			end
		end
	end

	// monitor: compares each result beat with the oldest prediction
	always @(posedge clk) begin
		slot_outcome_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_outcomes.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing pending, status %0d", status));
			end else begin
				want = expected_outcomes.pop_front();
				beats_checked++;
				if (status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d", status, want.status));
				else if (want.status <= pspr_pkg::STAT_TICK_DONE)
					status_seen[want.status]++;
				if (slot_index !== want.slot)
					report_mismatch($sformatf("slot_index got %0d want %0d (status %0d)",
						slot_index, want.slot, want.status));
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done === 1'b1)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no beat for %0d cycles", QUIET_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		for (int p = 0; p < POOLS; p++)
			for (int s = 0; s < SLOTS; s++) begin
				pool_live[p][s] = 1'b0;
				pool_prio[p][s] = '0;
				pool_life[p][s] = '0;
			end
		limit_model = pspr_pkg::CHILD_LIMIT_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: refused spawn, field extremes, zero life, ticks with spawn fields set
		queue_cmd(pspr_pkg::CMD_SPAWN, 1'b0, 3, 15, 65535, 255);
		queue_cmd(pspr_pkg::CMD_SPAWN, 1'b1, 0, 0, 0, 0);
		queue_cmd(pspr_pkg::CMD_TICK, 1'b0, 0, 0, 0, 0);
		queue_cmd(pspr_pkg::CMD_SPAWN, 1'b1, 0, 15, 65535, 0);
		queue_cmd(pspr_pkg::CMD_SPAWN, 1'b1, 0, 0, 1, 0);
		queue_cmd(pspr_pkg::CMD_SPAWN, 1'b1, 3, 5, 16'h5555, 8'h55);
		queue_cmd(pspr_pkg::CMD_SPAWN, 1'b1, 1, 10, 16'hAAAA, 8'hAA);
		queue_cmd(pspr_pkg::CMD_SPAWN, 1'b1, 2, 0, 2, 0);
		queue_cmd(pspr_pkg::CMD_SPAWN, 1'b1, 0, 0, 0, 0);
		queue_cmd(pspr_pkg::CMD_TICK, 1'b1, 3, 15, 65535, 1);
		queue_cmd(pspr_pkg::CMD_SPAWN, 1'b1, 2, 0, 300, 0);
		queue_cmd(pspr_pkg::CMD_SPAWN, 1'b1, 2, 0, 100, 0);
		queue_cmd(pspr_pkg::CMD_TICK, 1'b0, 0, 0, 0, 255);
		queue_cmd(pspr_pkg::CMD_SPAWN, 1'b1, 3, 15, 65535, 0);
		queue_cmd(pspr_pkg::CMD_SPAWN, 1'b1, 3, 0, 65535, 0);
		queue_cmd(pspr_pkg::CMD_TICK, 1'b1, 1, 7, 12345, 0);
		queue_random(80, 0, 15, 30);

		// limit zero: a priority-zero spawn always evicts the least-life priority-zero slot if one is live
		write_limit(0);
		queue_cmd(pspr_pkg::CMD_SPAWN, 1'b1, 1, 0, 50, 0);
		queue_random(80, 3, 10, 40);

		// limit at pool size, few ticks so one pool fills up
		write_limit(SLOTS);
		queue_random(110, 1, 4, 30);

		// tiny limit: frequent forced eviction among priority-zero slots
		write_limit(2);
		queue_random(90, 2, 10, 60);

		// limit above pool size: never forced
		write_limit(127);
		queue_random(60, 1, 10, 40);

		// back to the reset value
		write_limit(pspr_pkg::CHILD_LIMIT_RST);
		queue_random(30, 0, 15, 40);

		wait_drained();
		repeat (SLOTS + 16) @(posedge clk);
		if (expected_outcomes.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_outcomes.size()));
		$display("%0d commands, %0d result beats checked over child limits 48 0 64 2 127 48",
			cmds_sent, beats_checked);
		$display("free %0d, evicting %0d, no slot %0d, no ground %0d, ticks %0d",
			status_seen[pspr_pkg::STAT_PLACED_FREE], status_seen[pspr_pkg::STAT_PLACED_EVICT],
			status_seen[pspr_pkg::STAT_NO_SLOT], status_seen[pspr_pkg::STAT_NO_GROUND],
			status_seen[pspr_pkg::STAT_TICK_DONE]);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
